>>> hw/rtl/stgr_pkg.sv
// ---------------------------------------------------------------------------
// stgr_pkg: shared definitions for the square tile grid rotator
// command and status codes, register indexes, width helpers
// ---------------------------------------------------------------------------
package stgr_pkg;

    // fixed field widths
    localparam int ACTION_W    = 3;
    localparam int COORD_IN_W  = 7;
    localparam int GRID_REG_W  = 7;
    localparam int CELL_PORT_W = 32;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 1;

    // parameter defaults
    localparam int MAX_SIDE_DEF  = 64;
    localparam int CELL_BITS_DEF = 32;

    // register reset value
    localparam logic [GRID_REG_W-1:0] GRID_RESET = 7'd64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // command codes
    localparam logic [ACTION_W-1:0] ACT_READ        = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE       = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ROT_RIGHT   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ROT_LEFT    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_MIRROR_ROWS = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_MIRROR_COLS = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

    // walker control from the sequencer
    typedef struct packed {
        logic start;
        logic step;
    } walk_ctl_t;

    // bits to hold a side length up to and including max_side
    function automatic int side_w(input int max_side);
        return $clog2(max_side + 1);
    endfunction

    // bits to hold a coordinate below max_side
    function automatic int coord_w(input int max_side);
        return (max_side > 1) ? $clog2(max_side) : 1;
    endfunction

    // bits to address max_side * max_side cells
    function automatic int addr_w(input int max_side);
        return (max_side * max_side > 1) ? $clog2(max_side * max_side) : 1;
    endfunction

endpackage

>>> hw/rtl/stgr_walker.sv
// ---------------------------------------------------------------------------
// stgr_walker: address walker for whole-grid transforms
// steps row-major over an s-by-s region, gives the source and target cells
// ---------------------------------------------------------------------------
module stgr_walker #(
    parameter int MAX_SIDE = stgr_pkg::MAX_SIDE_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  stgr_pkg::walk_ctl_t                     ctl,
    input  logic [stgr_pkg::ACTION_W-1:0]           kind,
    input  logic [stgr_pkg::side_w(MAX_SIDE)-1:0]   side,
    output logic [stgr_pkg::addr_w(MAX_SIDE)-1:0]   src,
    output logic [stgr_pkg::addr_w(MAX_SIDE)-1:0]   dst,
    output logic                                    last
);
    import stgr_pkg::*;

    localparam int SIDE_W  = side_w(MAX_SIDE);
    localparam int COORD_W = coord_w(MAX_SIDE);
    localparam int ADDR_W  = addr_w(MAX_SIDE);
    localparam int PROD_W  = SIDE_W + COORD_W;

    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [ADDR_W-1:0]  src_reg;
    logic [COORD_W-1:0] s_m1;
    logic [COORD_W-1:0] mul_sel;
    logic [COORD_W-1:0] add_sel;
    logic [PROD_W-1:0]  dst_full;

    assign s_m1 = COORD_W'(side - 1'b1);
    assign last = (x_reg == s_m1) && (y_reg == s_m1);
    assign src  = src_reg;

    // target cell is side * mul_sel + add_sel
    always_comb
    begin
        unique case (kind)
            ACT_ROT_RIGHT:
            begin
                mul_sel = x_reg;
                add_sel = s_m1 - y_reg;
            end
            ACT_ROT_LEFT:
            begin
                mul_sel = s_m1 - x_reg;
                add_sel = y_reg;
            end
            ACT_MIRROR_ROWS:
            begin
                mul_sel = s_m1 - y_reg;
                add_sel = x_reg;
            end
            default:
            begin
                mul_sel = y_reg;
                add_sel = s_m1 - x_reg;
            end
        endcase
    end

    assign dst_full = PROD_W'(side) * PROD_W'(mul_sel) + PROD_W'(add_sel);
    assign dst      = dst_full[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            y_reg   <= '0;
            src_reg <= '0;
        end
        else if (ctl.start)
        begin
            x_reg   <= '0;
            y_reg   <= '0;
            src_reg <= '0;
        end
        else if (ctl.step)
        begin
            src_reg <= src_reg + 1'b1;
            if (x_reg == s_m1)
            begin
                x_reg <= '0;
                y_reg <= y_reg + 1'b1;
            end
            else
            begin
                x_reg <= x_reg + 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/square_tile_grid_rotator_top.sv
// ---------------------------------------------------------------------------
// square_tile_grid_rotator_top: tile grid store with rotate and mirror
// row-major grid of cell words with read, write and whole-grid transforms
// ---------------------------------------------------------------------------
//
// channel  direction  handshake              payload
// -------  ---------  ---------------------  --------------------------------
// cmd      in         cmd_valid / cmd_ready  action, col, row, cell_value
// rsp      out        rsp_valid / rsp_ready  read_value, status
// cfg      in         cfg_we                 cfg_index, cfg_data
//
// write, no-op, out-of-range and refused commands answer straight from the idle state, back to back
// an in-range read passes through S_RD_WAIT, set by the registered read of the cell memory
// a transform on side S runs the accepting cycle, one pass that copies the grid into
//   the scratch memory, the gap state, a second pass that writes every cell back to
//   its target place, and the finish state
// after reset a clearing pass over all MAX_SIDE*MAX_SIDE cells zeroes the cell memory;
//   cmd_ready stays low during it, cfg writes are taken as ever
// a command is taken only while the response register is free or being drained
//
module square_tile_grid_rotator_top #(
    parameter int MAX_SIDE  = stgr_pkg::MAX_SIDE_DEF,
    parameter int CELL_BITS = stgr_pkg::CELL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  logic [stgr_pkg::ACTION_W-1:0]       action,
    input  logic [stgr_pkg::COORD_IN_W-1:0]     col,
    input  logic [stgr_pkg::COORD_IN_W-1:0]     row,
    input  logic [stgr_pkg::CELL_PORT_W-1:0]    cell_value,
    // response channel
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic [stgr_pkg::CELL_PORT_W-1:0]    read_value,
    output logic [stgr_pkg::STATUS_W-1:0]       status,
    // configuration port
    input  logic                                cfg_we,
    input  logic [stgr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stgr_pkg::GRID_REG_W-1:0]     cfg_data
);
    import stgr_pkg::*;

    localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
    localparam int SIDE_W  = side_w(MAX_SIDE);
    localparam int ADDR_W  = addr_w(MAX_SIDE);
    localparam int CMP_W   = (SIDE_W > GRID_REG_W) ? SIDE_W : GRID_REG_W;
    localparam int IDX_W   = 2 * CMP_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_COPY,
        S_GAP,
        S_MOVE,
        S_FINISH
    } state_t;

    // configuration registers
    logic [GRID_REG_W-1:0] grid_width_reg;
    logic [GRID_REG_W-1:0] grid_height_reg;

    // sequencer state and registered response
    state_t                state_reg;
    logic [ADDR_W-1:0]     clr_cnt_reg;
    logic                  rsp_valid_reg;
    logic [CELL_PORT_W-1:0] read_value_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [SIDE_W-1:0]     side_reg;
    logic [ACTION_W-1:0]   kind_reg;

    // copy/move pipe: a read issued last cycle is written back this cycle
    logic                  pipe_vld_reg;
    logic                  pipe_to_cell_reg;
    logic [ADDR_W-1:0]     pipe_addr_reg;

    // memories
    logic [CELL_BITS-1:0]  cell_mem [DEPTH];
    logic [CELL_BITS-1:0]  scratch_mem [DEPTH];
    logic [CELL_BITS-1:0]  cell_rdata_reg;
    logic [CELL_BITS-1:0]  scratch_rdata_reg;

    logic                  cell_re;
    logic [ADDR_W-1:0]     cell_raddr;
    logic                  cell_we;
    logic [ADDR_W-1:0]     cell_waddr;
    logic [CELL_BITS-1:0]  cell_wdata;
    logic                  scratch_re;
    logic                  scratch_we;

    // command decode
    logic                  cmd_fire;
    logic [SIDE_W-1:0]     eff_w;
    logic [SIDE_W-1:0]     eff_h;
    logic                  in_range;
    logic                  is_square;
    logic [IDX_W-1:0]      idx_full;
    logic [ADDR_W-1:0]     cell_idx;
    logic                  cmd_rd;
    logic                  cmd_wr;
    logic                  xform_go;

    // walker
    walk_ctl_t             walk_ctl;
    logic [ADDR_W-1:0]     walk_src;
    logic [ADDR_W-1:0]     walk_dst;
    logic                  walk_last;

    // ---------------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_RESET;
            grid_height_reg <= GRID_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // registers above the maximum side saturate to it
    assign eff_w = (CMP_W'(grid_width_reg) > CMP_W'(MAX_SIDE)) ?
                   SIDE_W'(MAX_SIDE) : SIDE_W'(grid_width_reg);
    assign eff_h = (CMP_W'(grid_height_reg) > CMP_W'(MAX_SIDE)) ?
                   SIDE_W'(MAX_SIDE) : SIDE_W'(grid_height_reg);

    // ---------------------------------------------------------------------
    // command decode
    // ---------------------------------------------------------------------
    assign cmd_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign cmd_fire  = cmd_valid && cmd_ready;

    assign in_range  = (CMP_W'(col) < CMP_W'(eff_w)) && (CMP_W'(row) < CMP_W'(eff_h));
    assign is_square = (eff_w == eff_h) && (eff_w != '0);

    // flat position row * width + col, always below the store depth when in range
    assign idx_full  = IDX_W'(row) * IDX_W'(eff_w) + IDX_W'(col);
    assign cell_idx  = idx_full[ADDR_W-1:0];

    assign cmd_rd    = cmd_fire && in_range && (action == ACT_READ);
    assign cmd_wr    = cmd_fire && in_range && (action == ACT_WRITE);
    assign xform_go  = cmd_fire && is_square &&
                       ((action == ACT_ROT_RIGHT) || (action == ACT_ROT_LEFT) ||
                        (action == ACT_MIRROR_ROWS) || (action == ACT_MIRROR_COLS));

    // ---------------------------------------------------------------------
    // transform address walker
    // ---------------------------------------------------------------------
    assign walk_ctl.start = xform_go || (state_reg == S_GAP);
    assign walk_ctl.step  = (state_reg == S_COPY) || (state_reg == S_MOVE);

    stgr_walker #(
        .MAX_SIDE (MAX_SIDE)
    ) u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (walk_ctl),
        .kind  (kind_reg),
        .side  (side_reg),
        .src   (walk_src),
        .dst   (walk_dst),
        .last  (walk_last)
    );

    // ---------------------------------------------------------------------
    // memory port selection
    // ---------------------------------------------------------------------
    always_comb
    begin
        cell_re    = cmd_rd;
        cell_raddr = cell_idx;
        cell_we    = cmd_wr;
        cell_waddr = cell_idx;
        cell_wdata = CELL_BITS'(cell_value);

        // clearing pass right after reset
        if (state_reg == S_CLEAR)
        begin
            cell_we    = 1'b1;
            cell_waddr = clr_cnt_reg;
            cell_wdata = '0;
        end

        // copy pass reads the grid in flat order
        if (state_reg == S_COPY)
        begin
            cell_re    = 1'b1;
            cell_raddr = walk_src;
        end

        // move pass writes each scratch word to its target place
        if (pipe_vld_reg && pipe_to_cell_reg)
        begin
            cell_we    = 1'b1;
            cell_waddr = pipe_addr_reg;
            cell_wdata = scratch_rdata_reg;
        end
    end

    assign scratch_re = (state_reg == S_MOVE);
    assign scratch_we = pipe_vld_reg && !pipe_to_cell_reg;

    // cell memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cell_re)
            cell_rdata_reg <= cell_mem[cell_raddr];
        if (cell_we)
            cell_mem[cell_waddr] <= cell_wdata;
    end

    // scratch memory: holds the grid copy during a transform
    always_ff @(posedge clk)
    begin
        if (scratch_re)
            scratch_rdata_reg <= scratch_mem[walk_src];
        if (scratch_we)
            scratch_mem[pipe_addr_reg] <= cell_rdata_reg;
    end

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            rsp_valid_reg    <= 1'b0;
            read_value_reg   <= '0;
            status_reg       <= ST_DONE;
            side_reg         <= '0;
            kind_reg         <= ACT_READ;
            pipe_vld_reg     <= 1'b0;
            pipe_to_cell_reg <= 1'b0;
            pipe_addr_reg    <= '0;
        end
        else
        begin
            // response taken by the consumer; a new load below wins
            if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end

                S_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        read_value_reg <= '0;
                        unique case (action)
                            ACT_READ:
                            begin
                                if (in_range)
                                    state_reg <= S_RD_WAIT;
                                else
                                begin
                                    status_reg    <= ST_RANGE;
                                    rsp_valid_reg <= 1'b1;
                                end
                            end
                            ACT_WRITE:
                            begin
                                status_reg    <= in_range ? ST_DONE : ST_RANGE;
                                rsp_valid_reg <= 1'b1;
                            end
                            ACT_ROT_RIGHT, ACT_ROT_LEFT, ACT_MIRROR_ROWS,
                            ACT_MIRROR_COLS:
                            begin
                                if (is_square)
                                begin
                                    side_reg  <= eff_w;
                                    kind_reg  <= action;
                                    state_reg <= S_COPY;
                                end
                                else
                                begin
                                    status_reg    <= ST_REFUSED;
                                    rsp_valid_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                                // unused codes do nothing
                                status_reg    <= ST_DONE;
                                rsp_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end

                S_RD_WAIT:
                begin
                    read_value_reg <= CELL_PORT_W'(cell_rdata_reg);
                    status_reg     <= ST_DONE;
                    rsp_valid_reg  <= 1'b1;
                    state_reg      <= S_IDLE;
                end

                S_COPY:
                begin
                    pipe_vld_reg     <= 1'b1;
                    pipe_to_cell_reg <= 1'b0;
                    pipe_addr_reg    <= walk_src;
                    if (walk_last)
                        state_reg <= S_GAP;
                end

                S_GAP:
                begin
                    // last copy write lands here, before the move pass reads
                    pipe_vld_reg <= 1'b0;
                    state_reg    <= S_MOVE;
                end

                S_MOVE:
                begin
                    pipe_vld_reg     <= 1'b1;
                    pipe_to_cell_reg <= 1'b1;
                    pipe_addr_reg    <= walk_dst;
                    if (walk_last)
                        state_reg <= S_FINISH;
                end

                S_FINISH:
                begin
                    pipe_vld_reg   <= 1'b0;
                    read_value_reg <= '0;
                    status_reg     <= ST_DONE;
                    rsp_valid_reg  <= 1'b1;
                    state_reg      <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
`ifndef SYNTHESIS
    // no response can appear while the store is still being cleared
    a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !rsp_valid_reg)
        else $error("response valid during clearing pass");

    // at most one source drives the cell write port in a cycle
    a_one_cell_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({(state_reg == S_CLEAR), cmd_wr, (pipe_vld_reg && pipe_to_cell_reg)}))
        else $error("cell memory write port conflict");

    // an in-range read waits in S_RD_WAIT for the memory before its done response
    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_rd |=> (state_reg == S_RD_WAIT) ##1 (rsp_valid_reg && status_reg == ST_DONE))
        else $error("read response not produced after memory latency");

    // a finished transform always answers done
    a_finish_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |=> (rsp_valid_reg && status_reg == ST_DONE &&
                                     !pipe_vld_reg))
        else $error("transform finish without done response");
`endif

endmodule

>>> tb/sv/square_tile_grid_rotator_top_tb.sv
// ---------------------------------------------------------------------------
// square_tile_grid_rotator_top_tb: self-checking bench for the tile grid rotator
// drives read, write, rotate and mirror commands over several grid sizes and
// idle patterns, predicts every response from a local copy of the cell store
// and compares each one field by field in arrival order
// ---------------------------------------------------------------------------
module square_tile_grid_rotator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stgr_pkg::*;

    localparam int MAX_SIDE       = MAX_SIDE_DEF;
    localparam int CELL_COUNT     = MAX_SIDE * MAX_SIDE;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    // slowest legal run stays well under this, even with every full-size
    // transform, the clearing pass and the worst receiver stalls
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int DRAIN_LIMIT    = 40_000;
    localparam int TAIL_CYCLES    = 16;
    localparam int RANDOM_PHASES  = 16;
    localparam int PHASE_ITEMS    = 60;
    localparam int HOLD_CYCLES    = 400;

    // action codes the block treats as no-ops
    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic [COORD_IN_W-1:0]  col;
        logic [COORD_IN_W-1:0]  row;
        logic [CELL_PORT_W-1:0] value;
    } grid_cmd_t;

    typedef struct packed {
        logic [CELL_PORT_W-1:0] read_value;
        logic [STATUS_W-1:0]    status;
    } grid_rsp_t;

    // block ports, all known from time zero
    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cmd_valid  = 1'b0;
    logic                   cmd_ready;
    logic [ACTION_W-1:0]    action     = ACT_READ;
    logic [COORD_IN_W-1:0]  col        = '0;
    logic [COORD_IN_W-1:0]  row        = '0;
    logic [CELL_PORT_W-1:0] cell_value = '0;
    logic                   rsp_valid;
    logic                   rsp_ready  = 1'b0;
    logic [CELL_PORT_W-1:0] read_value;
    logic [STATUS_W-1:0]    status;
    logic                   cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index  = REG_GRID_WIDTH;
    logic [GRID_REG_W-1:0]  cfg_data   = '0;

    // local copy of the grid state and the size registers
    logic [CELL_PORT_W-1:0] grid_cells [CELL_COUNT];
    logic [CELL_PORT_W-1:0] grid_copy  [CELL_COUNT];
    logic [GRID_REG_W-1:0]  model_width_reg  = GRID_RESET;
    logic [GRID_REG_W-1:0]  model_height_reg = GRID_RESET;

    // responses predicted but not yet seen, oldest first
    grid_rsp_t pending_rsp [$];

    // idle control shared by sender and receiver
    int cmd_gap_pct      = 0;
    int rsp_stall_pct    = 0;
    int rsp_hold_request = 0;
    int rsp_hold_left    = 0;

    // bookkeeping
    int fail_count         = 0;
    int items_sent         = 0;
    int transforms_applied = 0;
    int refused_count      = 0;
    int range_count        = 0;
    int rsp_seen           = 0;

    square_tile_grid_rotator_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .action     (action),
        .col        (col),
        .row        (row),
        .cell_value (cell_value),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .read_value (read_value),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("[square_tile_grid_rotator_top] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // registers above the maximum side saturate
    function automatic int eff_side(input logic [GRID_REG_W-1:0] r);
        return (int'(r) > MAX_SIDE) ? MAX_SIDE : int'(r);
    endfunction

    // apply one command to the local grid and return the response it gives
    function automatic grid_rsp_t apply_grid_cmd(input grid_cmd_t c);
        int w;
        int h;
        int s;
        int dst;
        grid_rsp_t r;
        w = eff_side(model_width_reg);
        h = eff_side(model_height_reg);
        r.read_value = '0;
        r.status     = ST_DONE;
        case (c.action)
            ACT_READ, ACT_WRITE:
            begin
                // coordinates are checked against the effective size, not the store
                if (int'(c.col) >= w || int'(c.row) >= h)
                begin
                    r.status = ST_RANGE;
                    range_count++;
                end
                else if (c.action == ACT_READ)
                    r.read_value = grid_cells[int'(c.row) * w + int'(c.col)];
                else
                    grid_cells[int'(c.row) * w + int'(c.col)] = c.value;
            end
            ACT_ROT_RIGHT, ACT_ROT_LEFT, ACT_MIRROR_ROWS, ACT_MIRROR_COLS:
            begin
                // only a square, non-empty grid gets transformed
                if (w != h || w == 0)
                begin
                    r.status = ST_REFUSED;
                    refused_count++;
                end
                else
                begin
                    s = w;
                    for (int i = 0; i < s * s; i++)
                        grid_copy[i] = grid_cells[i];
                    for (int y = 0; y < s; y++)
                    begin
                        for (int x = 0; x < s; x++)
                        begin
                            case (c.action)
                                ACT_ROT_RIGHT:   dst = s * x + (s - 1 - y);
                                ACT_ROT_LEFT:    dst = s * (s - 1 - x) + y;
                                ACT_MIRROR_ROWS: dst = s * (s - 1 - y) + x;
                                default:         dst = s * y + (s - 1 - x);
                            endcase
                            grid_cells[dst] = grid_copy[s * y + x];
                        end
                    end
                    transforms_applied++;
                end
            end
            default: ;  // spare codes: no-op, plain done
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // response side: random ready, optional long hold, in-order check
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        // a hold request is loaded here and counted down cycle by cycle
        if (rsp_hold_request != 0)
        begin
            rsp_hold_left    = rsp_hold_request;
            rsp_hold_request = 0;
        end
        if (rsp_hold_left != 0)
        begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
        end
        else
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        grid_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_seen++;
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected response: read_value %h status %0d", read_value, status);
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (read_value !== want.read_value)
                begin
                    $error("read_value expected %h actual %h", want.read_value, read_value);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, status);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------

    function automatic grid_cmd_t mk_cmd(input logic [ACTION_W-1:0] a,
                                         input int c, input int r,
                                         input logic [CELL_PORT_W-1:0] v);
        grid_cmd_t m;
        m.action = a;
        m.col    = COORD_IN_W'(c);
        m.row    = COORD_IN_W'(r);
        m.value  = v;
        return m;
    endfunction

    // offer one item, hold it until taken, then record its expected response
    // returns right after the accepting edge with cmd_valid still high
    task automatic issue_cmd(input grid_cmd_t c);
        if (cmd_gap_pct != 0 && $urandom_range(99) < cmd_gap_pct)
        begin
            cmd_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < cmd_gap_pct);
        end
        cmd_valid  <= 1'b1;
        action     <= c.action;
        col        <= c.col;
        row        <= c.row;
        cell_value <= c.value;
        do @(posedge clk); while (!cmd_ready);
        pending_rsp.push_back(apply_grid_cmd(c));
        items_sent++;
    endtask

    // resize the grid once every outstanding response is back
    // both registers go in back to back so cfg_we is raised and lowered once
    task automatic set_grid_size(input logic [GRID_REG_W-1:0] w,
                                 input logic [GRID_REG_W-1:0] h);
        cmd_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        model_width_reg = w;
        cfg_index <= REG_GRID_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        model_height_reg = h;
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CELL_PORT_W-1:0] random_cell_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ACTION_W-1:0] random_action();
        return ACTION_W'($urandom_range(7));
    endfunction

    // mostly well-formed traffic inside the grid, some out-of-range and spare codes
    function automatic grid_cmd_t random_grid_cmd();
        int w;
        int h;
        int pick;
        int c;
        int r;
        logic [ACTION_W-1:0] a;
        w    = eff_side(model_width_reg);
        h    = eff_side(model_height_reg);
        pick = $urandom_range(99);
        c    = (w > 0) ? $urandom_range(w - 1) : $urandom_range(127);
        r    = (h > 0) ? $urandom_range(h - 1) : $urandom_range(127);
        if (pick < 38)
            a = ACT_READ;
        else if (pick < 76)
            a = ACT_WRITE;
        else if (pick < 92)
        begin
            case ($urandom_range(3))
                0:       a = ACT_ROT_RIGHT;
                1:       a = ACT_ROT_LEFT;
                2:       a = ACT_MIRROR_ROWS;
                default: a = ACT_MIRROR_COLS;
            endcase
            // transforms on big square grids run long, keep them rare
            if (w == h && w > 20 && $urandom_range(99) != 0)
                a = ACT_READ;
        end
        else
        begin
            // noise: any code, any coordinate
            a = random_action();
            c = $urandom_range(127);
            r = $urandom_range(127);
        end
        return mk_cmd(a, c, r, random_cell_word());
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset contents, corner writes and reads, out-of-range access, spare codes
    task automatic test_cell_access();
        issue_cmd(mk_cmd(ACT_READ, 0, 0, '1));
        issue_cmd(mk_cmd(ACT_READ, 63, 63, '0));
        issue_cmd(mk_cmd(ACT_WRITE, 0, 0, 32'hFFFF_FFFF));
        issue_cmd(mk_cmd(ACT_WRITE, 63, 0, 32'hA5A5_A5A5));
        issue_cmd(mk_cmd(ACT_WRITE, 0, 63, 32'h5A5A_5A5A));
        issue_cmd(mk_cmd(ACT_WRITE, 63, 63, 32'h0000_0001));
        issue_cmd(mk_cmd(ACT_READ, 0, 0, '0));
        issue_cmd(mk_cmd(ACT_READ, 63, 63, '0));
        // just past the edge and at the far end of the coordinate range
        issue_cmd(mk_cmd(ACT_READ, 64, 0, '0));
        issue_cmd(mk_cmd(ACT_WRITE, 0, 64, 32'hDEAD_BEEF));
        issue_cmd(mk_cmd(ACT_READ, 127, 127, '0));
        issue_cmd(mk_cmd(ACT_WRITE, 127, 0, 32'h1234_5678));
        issue_cmd(mk_cmd(ACT_SPARE_6, 5, 7, $urandom));
        issue_cmd(mk_cmd(ACT_SPARE_7, 127, 127, '1));
    endtask

    // every transform on the full-size grid, corners read back after the first and the last
    task automatic test_full_transforms();
        issue_cmd(mk_cmd(ACT_ROT_RIGHT, 0, 0, '0));
        issue_cmd(mk_cmd(ACT_READ, 63, 0, '0));
        issue_cmd(mk_cmd(ACT_ROT_LEFT, 0, 0, '0));
        issue_cmd(mk_cmd(ACT_MIRROR_ROWS, 0, 0, '0));
        issue_cmd(mk_cmd(ACT_MIRROR_COLS, 0, 0, '0));
        issue_cmd(mk_cmd(ACT_READ, 0, 0, '0));
    endtask

    // non-square, empty, saturated and one-cell grids
    task automatic test_size_corners();
        set_grid_size(7'd3, 7'd5);
        issue_cmd(mk_cmd(ACT_ROT_RIGHT, 0, 0, '0));
        issue_cmd(mk_cmd(ACT_READ, 2, 4, '0));
        issue_cmd(mk_cmd(ACT_READ, 3, 0, '0));
        set_grid_size(7'd0, 7'd0);
        issue_cmd(mk_cmd(ACT_READ, 0, 0, '0));
        issue_cmd(mk_cmd(ACT_MIRROR_ROWS, 0, 0, '0));
        // 127 saturates to the maximum side, so this grid is square
        set_grid_size(7'd127, 7'd127);
        issue_cmd(mk_cmd(ACT_ROT_LEFT, 0, 0, '0));
        issue_cmd(mk_cmd(ACT_READ, 0, 63, '0));
        set_grid_size(7'd1, 7'd1);
        issue_cmd(mk_cmd(ACT_WRITE, 0, 0, 32'hC0DE_0001));
        issue_cmd(mk_cmd(ACT_MIRROR_COLS, 0, 0, '0));
        issue_cmd(mk_cmd(ACT_READ, 0, 0, '0));
    endtask

    // receiver holds off while the sender keeps pushing, the input must stall
    task automatic test_backpressure();
        set_grid_size(7'd8, 7'd8);
        cmd_gap_pct      = 0;
        rsp_stall_pct    = 0;
        rsp_hold_request = HOLD_CYCLES;
        repeat (32)
            issue_cmd(random_grid_cmd());
    endtask

    // many sizes, the phases cycling through four idle patterns
    task automatic test_random_phases();
        logic [GRID_REG_W-1:0] w;
        logic [GRID_REG_W-1:0] h;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                begin
                    w = GRID_REG_W'($urandom_range(8, 1));
                    h = w;
                end
                6:
                begin
                    w = GRID_REG_W'($urandom_range(8, 1));
                    h = GRID_REG_W'($urandom_range(9, 1));
                end
                7:
                begin
                    w = GRID_REG_W'($urandom_range(1) ? 0 : $urandom_range(6));
                    h = GRID_REG_W'($urandom_range(1) ? 0 : $urandom_range(6));
                end
                8:
                begin
                    w = GRID_REG_W'($urandom_range(20, 9));
                    h = w;
                end
                default:
                begin
                    w = GRID_REG_W'($urandom_range(127, 60));
                    h = GRID_REG_W'($urandom_range(127, 60));
                end
            endcase
            set_grid_size(w, h);
            case (p % 4)
                0:
                begin
                    cmd_gap_pct   = 0;
                    rsp_stall_pct = 0;
                end
                1:
                begin
                    cmd_gap_pct   = 64;
                    rsp_stall_pct = 0;
                end
                2:
                begin
                    cmd_gap_pct   = 0;
                    rsp_stall_pct = 64;
                end
                default:
                begin
                    cmd_gap_pct   = 21;
                    rsp_stall_pct = 21;
                end
            endcase
            repeat (PHASE_ITEMS)
                issue_cmd(random_grid_cmd());
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int drain_cycles;
        for (int i = 0; i < CELL_COUNT; i++)
            grid_cells[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // the clearing pass after reset shows up as cmd_ready held low
        test_cell_access();
        test_full_transforms();
        test_size_corners();
        test_backpressure();
        test_random_phases();

        cmd_valid    <= 1'b0;
        drain_cycles = 0;
        while (pending_rsp.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        // a little longer to catch any response nobody asked for
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_rsp.size() != 0)
        begin
            $error("%0d expected responses never arrived", pending_rsp.size());
            fail_count++;
        end

        $display("run covered %0d commands and %0d responses over many grid sizes",
                 items_sent, rsp_seen);
        $display("transforms applied %0d, refused %0d, out-of-range accesses %0d",
                 transforms_applied, refused_count, range_count);
        if (fail_count == 0)
            $display("[square_tile_grid_rotator_top] OK");
        else
            $display("[square_tile_grid_rotator_top] ERROR");
        $finish;
    end

endmodule
